>>> rtl/core/ppmd_pkg.sv
// Package for the PPM stream decoder: result kinds, error codes, parser phases,
// the queue entry type and byte class helpers. No dependencies.
`timescale 1ns / 1ps

package ppmd_pkg;

    localparam int unsigned MAX_DIM_DEF   = 65535;
    localparam int unsigned MAX_LEVEL_DEF = 65535;
    localparam int unsigned QDEPTH        = 4;
    localparam int unsigned QAW           = $clog2(QDEPTH);

    localparam logic [1:0] KIND_HDR    = 2'd0;
    localparam logic [1:0] KIND_SAMPLE = 2'd1;
    localparam logic [1:0] KIND_ERR    = 2'd2;

    localparam logic [2:0] ERR_MAGIC  = 3'd0;
    localparam logic [2:0] ERR_HDRNUM = 3'd1;
    localparam logic [2:0] ERR_OVF    = 3'd2;
    localparam logic [2:0] ERR_TOKEN  = 3'd3;
    localparam logic [2:0] ERR_EARLY  = 3'd4;

    localparam logic [3:0] PH_MAGIC_P = 4'd0;
    localparam logic [3:0] PH_MAGIC_D = 4'd1;
    localparam logic [3:0] PH_WIDTH   = 4'd2;
    localparam logic [3:0] PH_HEIGHT  = 4'd3;
    localparam logic [3:0] PH_MAXV    = 4'd4;
    localparam logic [3:0] PH_DATA    = 4'd5;
    localparam logic [3:0] PH_SIGN    = 4'd6;
    localparam logic [3:0] PH_DONE    = 4'd7;
    localparam logic [3:0] PH_HALT    = 4'd8;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_3     = 8'h33;
    localparam logic [7:0] CH_6     = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    localparam logic [16:0] TXT_SAT = 17'd65536;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [15:0] maxv;
        logic [16:0] raw;
        logic        last;
        logic [2:0]  err;
    } t_entry;

    function automatic logic is_ws(input logic [7:0] b);
        is_ws = (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        is_digit = (b >= 8'd48) && (b <= 8'd57);
    endfunction

endpackage

>>> rtl/core/ppm_stream_decoder.sv
// PPM decoder: one file byte a word in, header, sample or error words out.
// Parser takes one byte a cycle unless the queue is full (o_stall); the scaler
// (8-step restoring divide by maxval) takes one sample at a time. Header and
// error words skip the divide. Synchronous active-low reset returns the parser
// to the magic and empties the queue and output register.
`timescale 1ns / 1ps

module ppm_stream_decoder #(
    parameter int unsigned MAX_DIM   = ppmd_pkg::MAX_DIM_DEF,
    parameter int unsigned MAX_LEVEL = ppmd_pkg::MAX_LEVEL_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_op,
    input  logic [7:0]  i_byte_req,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_kind,
    output logic [15:0] o_width,
    output logic [15:0] o_height,
    output logic [15:0] o_max_value,
    output logic [7:0]  o_sample,
    output logic        o_last,
    output logic [2:0]  o_error_code
);

    logic             w_push, w_pop, w_full, w_empty, w_accept;
    ppmd_pkg::t_entry w_in, w_out;

    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    ppmd_front #(.MAX_DIM(MAX_DIM), .MAX_LEVEL(MAX_LEVEL)) u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_op     (i_op),
        .i_byte   (i_byte_req),
        .o_push   (w_push),
        .o_entry  (w_in)
    );

    ppmd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_entry (w_in),
        .i_pop   (w_pop),
        .o_entry (w_out),
        .o_full  (w_full),
        .o_empty (w_empty)
    );

    ppmd_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_entry      (w_out),
        .i_empty      (w_empty),
        .o_pop        (w_pop),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_width      (o_width),
        .o_height     (o_height),
        .o_max_value  (o_max_value),
        .o_sample     (o_sample),
        .o_last       (o_last),
        .o_error_code (o_error_code)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_full |-> !w_push)
        else $error("push into full queue");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> !w_empty)
        else $error("pop from empty queue");

    a_last_on_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_kind != ppmd_pkg::KIND_SAMPLE) |-> !o_last)
        else $error("last flag on non-sample word");

endmodule

>>> rtl/core/ppmd_front.sv
// Byte parser: magic, header numbers, text and raw data tokens.
// Pushes one entry per result into the queue. Depends on ppmd_pkg.
`timescale 1ns / 1ps

module ppmd_front #(
    parameter int unsigned MAX_DIM   = ppmd_pkg::MAX_DIM_DEF,
    parameter int unsigned MAX_LEVEL = ppmd_pkg::MAX_LEVEL_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_accept,
    input  logic             i_op,
    input  logic [7:0]       i_byte,
    output logic             o_push,
    output ppmd_pkg::t_entry o_entry
);

    localparam logic [7:0] CH_ZERO = ppmd_pkg::CH_ZERO;

    logic [3:0]  r_phase, n_phase;
    logic        r_bin, n_bin;
    logic        r_cmt, n_cmt;
    logic        r_tok, n_tok;
    logic        r_neg, n_neg;
    logic [16:0] r_acc, n_acc;
    logic [15:0] r_width, n_width;
    logic [15:0] r_height, n_height;
    logic [15:0] r_maxv, n_maxv;
    logic [33:0] r_left, n_left;
    logic [31:0] r_prod;

    logic [3:0]  dig;
    logic [19:0] nv;
    logic [19:0] limit;
    logic [33:0] left_dec;

    assign dig      = i_byte[3:0] - CH_ZERO[3:0];
    assign nv       = ({3'b0, r_acc} << 3) + ({3'b0, r_acc} << 1) + {16'b0, dig};
    assign limit    = (r_phase == ppmd_pkg::PH_MAXV) ? 20'(MAX_LEVEL) : 20'(MAX_DIM);
    assign left_dec = (r_left != 34'd0) ? r_left - 34'd1 : r_left;

    always_comb begin
        n_phase  = r_phase;
        n_bin    = r_bin;
        n_cmt    = r_cmt;
        n_tok    = r_tok;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_width  = r_width;
        n_height = r_height;
        n_maxv   = r_maxv;
        n_left   = r_left;
        o_push   = 1'b0;
        o_entry  = '0;
        o_entry.maxv = r_maxv;
        if (i_accept) begin
            if (i_op) begin
                if (r_phase == ppmd_pkg::PH_DATA && !r_bin && r_tok && r_left == 34'd1) begin
                    o_push       = 1'b1;
                    o_entry.kind = ppmd_pkg::KIND_SAMPLE;
                    o_entry.raw  = r_neg ? 17'd0 : r_acc;
                    o_entry.last = 1'b1;
                end else if (r_phase != ppmd_pkg::PH_MAGIC_P && r_phase != ppmd_pkg::PH_DONE
                             && r_phase != ppmd_pkg::PH_HALT) begin
                    o_push       = 1'b1;
                    o_entry.kind = ppmd_pkg::KIND_ERR;
                    o_entry.err  = ppmd_pkg::ERR_EARLY;
                end
                n_phase  = ppmd_pkg::PH_MAGIC_P;
                n_bin    = 1'b0;
                n_cmt    = 1'b0;
                n_tok    = 1'b0;
                n_neg    = 1'b0;
                n_acc    = '0;
                n_width  = '0;
                n_height = '0;
                n_maxv   = '0;
                n_left   = '0;
            end else begin
                unique case (r_phase)
                    ppmd_pkg::PH_MAGIC_P: begin
                        if (!ppmd_pkg::is_ws(i_byte)) begin
                            if (i_byte == ppmd_pkg::CH_P) begin
                                n_phase = ppmd_pkg::PH_MAGIC_D;
                            end else begin
                                o_push       = 1'b1;
                                o_entry.kind = ppmd_pkg::KIND_ERR;
                                o_entry.err  = ppmd_pkg::ERR_MAGIC;
                                n_phase      = ppmd_pkg::PH_HALT;
                            end
                        end
                    end
                    ppmd_pkg::PH_MAGIC_D: begin
                        if (i_byte == ppmd_pkg::CH_3 || i_byte == ppmd_pkg::CH_6) begin
                            n_bin   = (i_byte == ppmd_pkg::CH_6);
                            n_phase = ppmd_pkg::PH_WIDTH;
                            n_cmt   = 1'b0;
                            n_tok   = 1'b0;
                            n_acc   = '0;
                        end else begin
                            o_push       = 1'b1;
                            o_entry.kind = ppmd_pkg::KIND_ERR;
                            o_entry.err  = ppmd_pkg::ERR_MAGIC;
                            n_phase      = ppmd_pkg::PH_HALT;
                        end
                    end
                    ppmd_pkg::PH_WIDTH, ppmd_pkg::PH_HEIGHT, ppmd_pkg::PH_MAXV: begin
                        if (r_cmt) begin
                            if (i_byte == ppmd_pkg::CH_LF) begin
                                n_cmt = 1'b0;
                            end
                        end else if (!r_tok) begin
                            if (ppmd_pkg::is_ws(i_byte)) begin
                                n_tok = 1'b0;
                            end else if (i_byte == ppmd_pkg::CH_HASH) begin
                                n_cmt = 1'b1;
                            end else if (!ppmd_pkg::is_digit(i_byte)) begin
                                o_push       = 1'b1;
                                o_entry.kind = ppmd_pkg::KIND_ERR;
                                o_entry.err  = ppmd_pkg::ERR_HDRNUM;
                                n_phase      = ppmd_pkg::PH_HALT;
                            end else if ({16'b0, dig} > limit) begin
                                o_push       = 1'b1;
                                o_entry.kind = ppmd_pkg::KIND_ERR;
                                o_entry.err  = ppmd_pkg::ERR_OVF;
                                n_phase      = ppmd_pkg::PH_HALT;
                            end else begin
                                n_tok = 1'b1;
                                n_acc = {13'b0, dig};
                            end
                        end else if (ppmd_pkg::is_digit(i_byte)) begin
                            if (nv > limit) begin
                                o_push       = 1'b1;
                                o_entry.kind = ppmd_pkg::KIND_ERR;
                                o_entry.err  = ppmd_pkg::ERR_OVF;
                                n_phase      = ppmd_pkg::PH_HALT;
                            end else begin
                                n_acc = nv[16:0];
                            end
                        end else if (ppmd_pkg::is_ws(i_byte)
                                     || (i_byte == ppmd_pkg::CH_HASH
                                         && r_phase != ppmd_pkg::PH_MAXV)) begin
                            n_tok = 1'b0;
                            n_acc = '0;
                            if (r_acc == 17'd0) begin
                                o_push       = 1'b1;
                                o_entry.kind = ppmd_pkg::KIND_ERR;
                                o_entry.err  = ppmd_pkg::ERR_HDRNUM;
                                n_phase      = ppmd_pkg::PH_HALT;
                            end else begin
                                n_cmt = (i_byte == ppmd_pkg::CH_HASH);
                                if (r_phase == ppmd_pkg::PH_WIDTH) begin
                                    n_width = r_acc[15:0];
                                    n_phase = ppmd_pkg::PH_HEIGHT;
                                end else if (r_phase == ppmd_pkg::PH_HEIGHT) begin
                                    n_height = r_acc[15:0];
                                    n_phase  = ppmd_pkg::PH_MAXV;
                                end else begin
                                    n_maxv         = r_acc[15:0];
                                    n_left         = ({2'b0, r_prod} << 1) + {2'b0, r_prod};
                                    n_phase        = ppmd_pkg::PH_DATA;
                                    o_push         = 1'b1;
                                    o_entry.kind   = ppmd_pkg::KIND_HDR;
                                    o_entry.width  = r_width;
                                    o_entry.height = r_height;
                                    o_entry.maxv   = r_acc[15:0];
                                end
                            end
                        end else begin
                            o_push       = 1'b1;
                            o_entry.kind = ppmd_pkg::KIND_ERR;
                            o_entry.err  = ppmd_pkg::ERR_HDRNUM;
                            n_phase      = ppmd_pkg::PH_HALT;
                        end
                    end
                    ppmd_pkg::PH_DATA, ppmd_pkg::PH_SIGN: begin
                        if (r_phase == ppmd_pkg::PH_DATA && r_bin) begin
                            o_push       = 1'b1;
                            o_entry.kind = ppmd_pkg::KIND_SAMPLE;
                            o_entry.raw  = {9'b0, i_byte};
                            n_left       = left_dec;
                            if (left_dec == 34'd0) begin
                                o_entry.last = 1'b1;
                                n_phase      = ppmd_pkg::PH_DONE;
                            end
                        end else if (r_phase == ppmd_pkg::PH_SIGN) begin
                            if (ppmd_pkg::is_digit(i_byte)) begin
                                n_phase = ppmd_pkg::PH_DATA;
                                n_tok   = 1'b1;
                                n_acc   = {13'b0, dig};
                            end else begin
                                o_push       = 1'b1;
                                o_entry.kind = ppmd_pkg::KIND_ERR;
                                o_entry.err  = ppmd_pkg::ERR_TOKEN;
                                n_phase      = ppmd_pkg::PH_HALT;
                            end
                        end else if (!r_tok) begin
                            if (ppmd_pkg::is_ws(i_byte)) begin
                                n_tok = 1'b0;
                            end else if (ppmd_pkg::is_digit(i_byte)) begin
                                n_tok = 1'b1;
                                n_neg = 1'b0;
                                n_acc = {13'b0, dig};
                            end else if (i_byte == ppmd_pkg::CH_MINUS
                                         || i_byte == ppmd_pkg::CH_PLUS) begin
                                n_neg   = (i_byte == ppmd_pkg::CH_MINUS);
                                n_acc   = '0;
                                n_phase = ppmd_pkg::PH_SIGN;
                            end else begin
                                o_push       = 1'b1;
                                o_entry.kind = ppmd_pkg::KIND_ERR;
                                o_entry.err  = ppmd_pkg::ERR_TOKEN;
                                n_phase      = ppmd_pkg::PH_HALT;
                            end
                        end else if (ppmd_pkg::is_digit(i_byte)) begin
                            n_acc = (nv > {3'b0, ppmd_pkg::TXT_SAT}) ? ppmd_pkg::TXT_SAT
                                                                      : nv[16:0];
                        end else if (ppmd_pkg::is_ws(i_byte)) begin
                            o_push       = 1'b1;
                            o_entry.kind = ppmd_pkg::KIND_SAMPLE;
                            o_entry.raw  = r_neg ? 17'd0 : r_acc;
                            n_left       = left_dec;
                            n_tok        = 1'b0;
                            n_neg        = 1'b0;
                            n_acc        = '0;
                            if (left_dec == 34'd0) begin
                                o_entry.last = 1'b1;
                                n_phase      = ppmd_pkg::PH_DONE;
                            end
                        end else begin
                            o_push       = 1'b1;
                            o_entry.kind = ppmd_pkg::KIND_ERR;
                            o_entry.err  = ppmd_pkg::ERR_TOKEN;
                            n_phase      = ppmd_pkg::PH_HALT;
                        end
                    end
                    default: begin
                        n_phase = r_phase;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= r_width * r_height;
        if (!i_rst_n) begin
            r_phase  <= ppmd_pkg::PH_MAGIC_P;
            r_bin    <= 1'b0;
            r_cmt    <= 1'b0;
            r_tok    <= 1'b0;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_width  <= '0;
            r_height <= '0;
            r_maxv   <= '0;
            r_left   <= '0;
        end else begin
            r_phase  <= n_phase;
            r_bin    <= n_bin;
            r_cmt    <= n_cmt;
            r_tok    <= n_tok;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_width  <= n_width;
            r_height <= n_height;
            r_maxv   <= n_maxv;
            r_left   <= n_left;
        end
    end

endmodule

>>> rtl/core/ppmd_queue.sv
// Short entry queue between parser and scaler.
// Depends on ppmd_pkg for the entry type and depth.
`timescale 1ns / 1ps

module ppmd_queue (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  ppmd_pkg::t_entry i_entry,
    input  logic             i_pop,
    output ppmd_pkg::t_entry o_entry,
    output logic             o_full,
    output logic             o_empty
);

    ppmd_pkg::t_entry r_mem [ppmd_pkg::QDEPTH];
    logic [ppmd_pkg::QAW-1:0] r_wp, r_rp;
    logic [ppmd_pkg::QAW:0]   r_cnt;

    assign o_entry = r_mem[r_rp];
    assign o_full  = (r_cnt == (ppmd_pkg::QAW+1)'(ppmd_pkg::QDEPTH));
    assign o_empty = (r_cnt == '0);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (ppmd_pkg::QAW+1)'(i_push) - (ppmd_pkg::QAW+1)'(i_pop);
        end
    end

endmodule

>>> rtl/core/ppmd_back.sv
// Result stage: clamps and scales samples by a shift-subtract divide,
// then holds each word in the output register. Depends on ppmd_pkg.
`timescale 1ns / 1ps

module ppmd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  ppmd_pkg::t_entry i_entry,
    input  logic             i_empty,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_stall,
    output logic [1:0]       o_kind,
    output logic [15:0]      o_width,
    output logic [15:0]      o_height,
    output logic [15:0]      o_max_value,
    output logic [7:0]       o_sample,
    output logic             o_last,
    output logic [2:0]       o_error_code
);

    localparam logic [1:0] B_IDLE = 2'd0;
    localparam logic [1:0] B_DIV  = 2'd1;
    localparam logic [1:0] B_EMIT = 2'd2;

    logic [1:0]  r_st, n_st;
    logic [23:0] r_rem, n_rem;
    logic [22:0] r_dsr, n_dsr;
    logic [7:0]  r_q, n_q;
    logic [2:0]  r_cnt, n_cnt;
    logic        r_slast, n_slast;
    logic        r_ov, n_ov;
    logic [1:0]  r_kind, n_kind;
    logic [15:0] r_w, n_w, r_h, n_h, r_m, n_m;
    logic [7:0]  r_smp, n_smp;
    logic        r_olast, n_olast;
    logic [2:0]  r_err, n_err;

    logic        out_free;
    logic [15:0] mm, v;

    assign out_free = !r_ov || !i_stall;
    assign mm = (i_entry.maxv == 16'd0) ? 16'd1 : i_entry.maxv;
    assign v  = (i_entry.raw > {1'b0, mm}) ? mm : i_entry.raw[15:0];

    always_comb begin
        n_st    = r_st;
        n_rem   = r_rem;
        n_dsr   = r_dsr;
        n_q     = r_q;
        n_cnt   = r_cnt;
        n_slast = r_slast;
        n_ov    = r_ov && i_stall;
        n_kind  = r_kind;
        n_w     = r_w;
        n_h     = r_h;
        n_m     = r_m;
        n_smp   = r_smp;
        n_olast = r_olast;
        n_err   = r_err;
        o_pop   = 1'b0;
        unique case (r_st)
            B_IDLE: begin
                if (!i_empty) begin
                    if (i_entry.kind == ppmd_pkg::KIND_SAMPLE) begin
                        o_pop   = 1'b1;
                        n_rem   = {v, 8'b0} - {8'b0, v};
                        n_dsr   = {mm, 7'b0};
                        n_q     = '0;
                        n_cnt   = '0;
                        n_slast = i_entry.last;
                        n_st    = B_DIV;
                    end else if (out_free) begin
                        o_pop   = 1'b1;
                        n_ov    = 1'b1;
                        n_kind  = i_entry.kind;
                        n_w     = i_entry.width;
                        n_h     = i_entry.height;
                        n_m     = (i_entry.kind == ppmd_pkg::KIND_HDR) ? i_entry.maxv : 16'd0;
                        n_smp   = '0;
                        n_olast = 1'b0;
                        n_err   = i_entry.err;
                    end
                end
            end
            B_DIV: begin
                if (r_rem >= {1'b0, r_dsr}) begin
                    n_rem = r_rem - {1'b0, r_dsr};
                    n_q   = {r_q[6:0], 1'b1};
                end else begin
                    n_q   = {r_q[6:0], 1'b0};
                end
                n_dsr = r_dsr >> 1;
                n_cnt = r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    n_st = B_EMIT;
                end
            end
            B_EMIT: begin
                if (out_free) begin
                    n_ov    = 1'b1;
                    n_kind  = ppmd_pkg::KIND_SAMPLE;
                    n_w     = '0;
                    n_h     = '0;
                    n_m     = '0;
                    n_smp   = r_q;
                    n_olast = r_slast;
                    n_err   = ppmd_pkg::ERR_MAGIC;
                    n_st    = B_IDLE;
                end
            end
            default: begin
                n_st = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_dsr   <= n_dsr;
        r_q     <= n_q;
        r_cnt   <= n_cnt;
        r_slast <= n_slast;
        r_kind  <= n_kind;
        r_w     <= n_w;
        r_h     <= n_h;
        r_m     <= n_m;
        r_smp   <= n_smp;
        r_olast <= n_olast;
        r_err   <= n_err;
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            r_ov <= 1'b0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
        end
    end

    assign o_valid      = r_ov;
    assign o_kind       = r_kind;
    assign o_width      = r_w;
    assign o_height     = r_h;
    assign o_max_value  = r_m;
    assign o_sample     = r_smp;
    assign o_last       = r_olast;
    assign o_error_code = r_err;

endmodule
